/* rtl/core/wbd3_pkg.sv */
// wbd3_pkg: shared types and constants for the weighted 3x3 block downsampler
// payload structs, lane control struct, register indexes
// no dependencies

package wbd3_pkg;

    localparam int CHANNEL_BITS   = 16;
    localparam int NUM_CH         = 7;
    localparam int ROW_BITS       = CHANNEL_BITS + 2;
    localparam int SUM_BITS       = CHANNEL_BITS + 4;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_OUT_HEIGHT = 1024;
    localparam int OY_BITS        = 10;
    localparam int ROUND_BIAS     = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_HEIGHT = 2'd1;

    // position of a pixel inside its 3x3 block
    localparam logic [1:0] POS_FIRST = 2'd0;
    localparam logic [1:0] POS_MID   = 2'd1;
    localparam logic [1:0] POS_LAST  = 2'd2;

    typedef logic [CHANNEL_BITS-1:0] chan_t;
    typedef logic [SUM_BITS-1:0]     sum_t;

    typedef struct packed {
        chan_t color_red;
        chan_t color_green;
        chan_t color_blue;
        chan_t normal_x;
        chan_t normal_y;
        chan_t normal_z;
        chan_t depth_level;
    } pix_t;

    typedef struct packed {
        chan_t out_red;
        chan_t out_green;
        chan_t out_blue;
        chan_t out_normal_x;
        chan_t out_normal_y;
        chan_t out_normal_z;
        chan_t out_depth;
        logic  frame_end;
    } res_t;

    typedef struct packed {
        logic       accept;     // pixel transaction this cycle
        logic [1:0] col_pos;    // column position inside the block
        logic       first_row;  // top row of the block
        logic       mid_row;    // middle row of the block, weight 2
        logic       emit;       // bottom-right pixel, block complete
    } lane_ctrl_t;

endpackage

/* rtl/core/wbd3_ram.sv */
// wbd3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module wbd3_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/wbd3_lane.sv */
// wbd3_lane: one channel of the downsampler, row weighting and column accumulation
// depends on wbd3_pkg and wbd3_ram

module wbd3_lane #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                        clk,
    input  wbd3_pkg::lane_ctrl_t        ctrl,
    input  logic [(MAX_OUT_WIDTH > 1 ? $clog2(MAX_OUT_WIDTH) : 1)-1:0] col_addr,
    input  wbd3_pkg::chan_t             sample,
    output wbd3_pkg::sum_t              block_sum
);

    localparam int RB = wbd3_pkg::ROW_BITS;
    localparam int SB = wbd3_pkg::SUM_BITS;

    logic [RB-1:0]  row_reg;
    logic [RB-1:0]  row_next;
    logic [RB-1:0]  term;
    logic [SB-1:0]  contr;
    logic [SB-1:0]  col_sum;
    logic [SB-1:0]  col_rd;
    wbd3_pkg::sum_t sum_reg;
    logic           last_col;
    logic           col_wr;
    logic           col_rd_en;

    assign last_col  = (ctrl.col_pos == wbd3_pkg::POS_LAST);
    assign col_wr    = ctrl.accept && last_col;
    // fetch the stored column sum while the block row is still arriving
    assign col_rd_en = ctrl.accept && (ctrl.col_pos == wbd3_pkg::POS_MID);

    always_comb
    begin
        if (ctrl.col_pos == wbd3_pkg::POS_MID)
        begin
            term = {1'b0, sample, 1'b0};
        end
        else
        begin
            term = RB'(sample);
        end

        if (ctrl.col_pos == wbd3_pkg::POS_FIRST)
        begin
            row_next = term;
        end
        else
        begin
            row_next = row_reg + term;
        end

        if (ctrl.mid_row)
        begin
            contr = {1'b0, row_next, 1'b0};
        end
        else
        begin
            contr = {2'b00, row_next};
        end

        if (ctrl.first_row)
        begin
            col_sum = contr;
        end
        else
        begin
            col_sum = col_rd + contr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            row_reg <= row_next;
        end
        if (ctrl.emit)
        begin
            sum_reg <= col_sum;
        end
    end

    wbd3_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_OUT_WIDTH)
    ) u_col_ram (
        .clk     (clk),
        .wr_en   (col_wr),
        .wr_addr (col_addr),
        .wr_data (col_sum),
        .rd_en   (col_rd_en),
        .rd_addr (col_addr),
        .rd_data (col_rd)
    );

    assign block_sum = sum_reg;

endmodule

/* rtl/core/wbd3_merge.sv */
// wbd3_merge: rounds and clamps the lane sums and holds the result register
// depends on wbd3_pkg

module wbd3_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  blk_valid,
    input  wbd3_pkg::sum_t        blk_sum [wbd3_pkg::NUM_CH],
    input  logic                  blk_frame_end,
    output logic                  blk_take,
    output logic                  res_valid,
    input  logic                  res_ready,
    output wbd3_pkg::res_t        res
);

    localparam int CB = wbd3_pkg::CHANNEL_BITS;
    localparam int SB = wbd3_pkg::SUM_BITS;

    logic           res_valid_reg;
    logic           res_valid_next;
    wbd3_pkg::res_t res_reg;
    wbd3_pkg::chan_t rounded [wbd3_pkg::NUM_CH];
    logic [SB:0]    biased [wbd3_pkg::NUM_CH];

    // (sum + 8) >> 4 with saturation to full scale
    always_comb
    begin
        for (int i = 0; i < wbd3_pkg::NUM_CH; i++)
        begin
            biased[i] = {1'b0, blk_sum[i]} + (SB+1)'(wbd3_pkg::ROUND_BIAS);
            if (biased[i][SB])
            begin
                rounded[i] = {CB{1'b1}};
            end
            else
            begin
                rounded[i] = biased[i][SB-1:4];
            end
        end
    end

    assign blk_take = blk_valid && (!res_valid_reg || res_ready);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (blk_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (blk_take)
        begin
            res_reg.out_red      <= rounded[0];
            res_reg.out_green    <= rounded[1];
            res_reg.out_blue     <= rounded[2];
            res_reg.out_normal_x <= rounded[3];
            res_reg.out_normal_y <= rounded[4];
            res_reg.out_normal_z <= rounded[5];
            res_reg.out_depth    <= rounded[6];
            res_reg.frame_end    <= blk_frame_end;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* rtl/core/weighted_block_downsample_3x3_core.sv */
// weighted_block_downsample_3x3_core: top level of the 3x3 weighted block downsampler
// depends on wbd3_pkg, wbd3_lane, wbd3_merge
//
// pixels of a frame of (3*out_width) x (3*out_height) arrive in raster order on the
// pix channel (valid/ready); each 3x3 block becomes one filtered pixel on the res
// channel, weights [1 2 1]x[1 2 1]/16 rounded half up, frame_end set on the last one.
// seven lanes, one per channel, each keep a row accumulator and a ram of column
// sums (one entry per output column); the merge stage rounds and registers results.
// throughput: one pixel per cycle while the output is not stalled, set by the column
// read-modify-write (read issued on the middle pixel, written on the last).
// a block's sum is registered on its bottom-right pixel, then in the merge output register.
// a result waiting on a stalled receiver sits in the output register while one more
// block is held in the lane sum stage; once both are full, pix_ready drops for
// every pixel until the receiver takes the waiting result.
// reset: out_width and out_height read as 1, position returns to frame start, no
// result pending; the column rams need no clearing since every block's top row
// ignores the read value. a cfg_write to either size register also restarts the frame.
// out_width/out_height of 0 act as 1, larger than the limits act as the limits.

module weighted_block_downsample_3x3_core #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_write,
    input  logic [wbd3_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [wbd3_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  logic                                      pix_valid,
    output logic                                      pix_ready,
    input  wbd3_pkg::pix_t                            pix,
    output logic                                      res_valid,
    input  logic                                      res_ready,
    output wbd3_pkg::res_t                            res
);

    localparam int OXW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int OYW = wbd3_pkg::OY_BITS;

    logic [OXW-1:0] w_last_reg, w_last_next;
    logic [OYW-1:0] h_last_reg, h_last_next;
    logic [1:0]     px_reg, px_next;
    logic [1:0]     py_reg, py_next;
    logic [OXW-1:0] ox_reg, ox_next;
    logic [OYW-1:0] oy_reg, oy_next;
    logic           blk_valid_reg, blk_valid_next;
    logic           blk_frame_end_reg;
    logic           accept;
    logic           emit;
    logic           blk_take;
    logic [31:0]    cfg_wide;
    logic [31:0]    cfg_minus;
    wbd3_pkg::lane_ctrl_t lane_ctrl;
    wbd3_pkg::chan_t      lane_in  [wbd3_pkg::NUM_CH];
    wbd3_pkg::sum_t       lane_sum [wbd3_pkg::NUM_CH];

    assign pix_ready = !blk_valid_reg || blk_take;
    assign accept    = pix_valid && pix_ready;
    assign emit      = accept && (px_reg == wbd3_pkg::POS_LAST)
                              && (py_reg == wbd3_pkg::POS_LAST);

    // register writes store the clamped last index, i.e. dimension minus one
    always_comb
    begin
        cfg_wide    = 32'(cfg_data);
        cfg_minus   = cfg_wide - 32'd1;
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                wbd3_pkg::REG_OUT_WIDTH:
                begin
                    if (cfg_wide == 32'd0)
                    begin
                        w_last_next = '0;
                    end
                    else if (cfg_wide > 32'(MAX_OUT_WIDTH))
                    begin
                        w_last_next = OXW'(MAX_OUT_WIDTH - 1);
                    end
                    else
                    begin
                        w_last_next = cfg_minus[OXW-1:0];
                    end
                end
                wbd3_pkg::REG_OUT_HEIGHT:
                begin
                    if (cfg_wide == 32'd0)
                    begin
                        h_last_next = '0;
                    end
                    else if (cfg_wide > 32'(wbd3_pkg::MAX_OUT_HEIGHT))
                    begin
                        h_last_next = OYW'(wbd3_pkg::MAX_OUT_HEIGHT - 1);
                    end
                    else
                    begin
                        h_last_next = cfg_minus[OYW-1:0];
                    end
                end
                default:
                begin
                    w_last_next = w_last_reg;
                end
            endcase
        end
    end

    // raster position split into block column/row and position inside the block
    always_comb
    begin
        px_next = px_reg;
        py_next = py_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        if (cfg_write && (cfg_index == wbd3_pkg::REG_OUT_WIDTH
                          || cfg_index == wbd3_pkg::REG_OUT_HEIGHT))
        begin
            px_next = '0;
            py_next = '0;
            ox_next = '0;
            oy_next = '0;
        end
        else if (accept)
        begin
            if (px_reg != wbd3_pkg::POS_LAST)
            begin
                px_next = px_reg + 2'd1;
            end
            else
            begin
                px_next = '0;
                if (ox_reg != w_last_reg)
                begin
                    ox_next = ox_reg + OXW'(1);
                end
                else
                begin
                    ox_next = '0;
                    if (py_reg != wbd3_pkg::POS_LAST)
                    begin
                        py_next = py_reg + 2'd1;
                    end
                    else
                    begin
                        py_next = '0;
                        if (oy_reg != h_last_reg)
                        begin
                            oy_next = oy_reg + OYW'(1);
                        end
                        else
                        begin
                            oy_next = '0;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        if (emit)
        begin
            blk_valid_next = 1'b1;
        end
        else if (blk_take)
        begin
            blk_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= '0;
            h_last_reg    <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            w_last_reg    <= w_last_next;
            h_last_reg    <= h_last_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            blk_valid_reg <= blk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            blk_frame_end_reg <= (ox_reg == w_last_reg) && (oy_reg == h_last_reg);
        end
    end

    always_comb
    begin
        lane_ctrl.accept    = accept;
        lane_ctrl.col_pos   = px_reg;
        lane_ctrl.first_row = (py_reg == wbd3_pkg::POS_FIRST);
        lane_ctrl.mid_row   = (py_reg == wbd3_pkg::POS_MID);
        lane_ctrl.emit      = emit;
    end

    assign lane_in[0] = pix.color_red;
    assign lane_in[1] = pix.color_green;
    assign lane_in[2] = pix.color_blue;
    assign lane_in[3] = pix.normal_x;
    assign lane_in[4] = pix.normal_y;
    assign lane_in[5] = pix.normal_z;
    assign lane_in[6] = pix.depth_level;

    for (genvar g = 0; g < wbd3_pkg::NUM_CH; g++)
    begin : g_lane
        wbd3_lane #(
            .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
        ) u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .col_addr  (ox_reg),
            .sample    (lane_in[g]),
            .block_sum (lane_sum[g])
        );
    end

    wbd3_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .blk_valid     (blk_valid_reg),
        .blk_sum       (lane_sum),
        .blk_frame_end (blk_frame_end_reg),
        .blk_take      (blk_take),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res)
    );

endmodule
